FILE: hw/rtl/cir_pkg.sv
// Shared types and constants for the contact impulse resolver.
package cir_pkg;

    localparam int MaxContactsDef = 16;
    localparam int FracBitsDef    = 16;
    localparam int ValW           = 32;
    localparam int ResW           = 17;
    localparam int CntW           = 5;

    localparam logic [1:0] ModeLoad0   = 2'd0;
    localparam logic [1:0] ModeLoad1   = 2'd1;
    localparam logic [1:0] ModeContact = 2'd2;

    typedef struct packed {
        logic [1:0]             mode;
        logic signed [ValW-1:0] vec_x;
        logic signed [ValW-1:0] vec_y;
        logic signed [ValW-1:0] vec_z;
        logic [ValW-1:0]        mass_value;
        logic [ResW-1:0]        restitution;
        logic [CntW-1:0]        contact_count;
    } in_beat_t;

    typedef struct packed {
        logic                   which_body;
        logic signed [ValW-1:0] new_vel_x;
        logic signed [ValW-1:0] new_vel_y;
        logic signed [ValW-1:0] new_vel_z;
        logic                   impulse_applied;
        logic                   last_result;
    } out_beat_t;

    // Request and response of the shared divider.
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

endpackage

FILE: hw/rtl/contact_impulse_resolver.sv
// Top level of the contact impulse resolver: body store, sequencer and shared divider.
//
// Body items (mode 0 and 1) store one body's velocity, mass and restitution when
// accepted and give no result. A contact item (mode 2) normalizes the
// collision normal, forms both inverse masses and applies a normal impulse that
// uses the smaller restitution, shared among the contact points, then emits two
// result beats: the first body, then the second. All long operations go through
// one shared bit-serial divider. A divide runs through the start, 64 steps and
// the handback of the quotient; the square root through a sum of the squares of
// three components, the start, 32 steps and the handback. A contact item runs
// through the two inverse masses, the root, three normal components, the dot
// product and the numerator, then for each body a share divide, a scale, a count
// divide and three velocity updates, and then the two beats. A zero contact count
// skips the count divide. A contact is skipped after the root for a zero normal
// or two immovable bodies, and at the numerator when its bodies separate. The
// next item can be accepted in the cycle after the last beat, in idle. The input
// is not ready while an item is in work or a result beat waits. Mode 3 is dropped.
module contact_impulse_resolver #(
    parameter int MAX_CONTACTS = cir_pkg::MaxContactsDef,
    parameter int FRAC_BITS    = cir_pkg::FracBitsDef
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cir_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cir_pkg::out_beat_t  m_data
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_INV0  = 12'b000000000010,
        ST_INV1  = 12'b000000000100,
        ST_SQRT  = 12'b000000001000,
        ST_NORM  = 12'b000000010000,
        ST_DOT   = 12'b000000100000,
        ST_NUM   = 12'b000001000000,
        ST_SHARE = 12'b000010000000,
        ST_SCALE = 12'b000100000000,
        ST_CNT   = 12'b001000000000,
        ST_APPLY = 12'b010000000000,
        ST_OUT   = 12'b100000000000
    } state_t;

    localparam logic [63:0] OneSq = 64'd1 << (2 * FRAC_BITS);
    localparam logic [31:0] MaxCnt = 32'(MAX_CONTACTS);

    state_t state_reg, state_next;

    logic signed [31:0] vel_reg [6];
    logic [31:0]        mass_reg [2];
    logic [16:0]        rest_reg [2];

    logic signed [31:0] n_reg [3];
    logic signed [33:0] nh_reg [3];
    logic [31:0]        inv_reg [2];
    logic [63:0]        len_reg;
    logic [4:0]         cnt_reg;
    logic signed [95:0] dot_reg;
    logic [63:0]        num_reg;
    logic [63:0]        s_reg;
    logic [1:0]         idx_reg;
    logic               body_reg;
    logic               wait_reg;
    logic               applied_reg;
    logic               out_body_reg;

    cir_pkg::div_req_t req;
    cir_pkg::div_rsp_t rsp;

    cir_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    logic [31:0] nmag;
    logic [63:0] sumsq;
    logic [63:0] closing;
    logic [32:0] inv_sum;
    logic [31:0] emin;
    logic signed [32:0] rv;
    logic [63:0] prod;
    logic signed [63:0] dprod;
    logic [31:0] nhmag;
    logic signed [35:0] vnew;
    logic signed [31:0] vsat;
    logic [2:0] vi;

    always_comb begin
        nmag = n_reg[idx_reg][31] ? 32'(-n_reg[idx_reg]) : 32'(n_reg[idx_reg]);
        sumsq = 64'(nmag) * 64'(nmag);
        // The closing speed is below 2^33 for any normal, so 34 bits carry it.
        closing = 64'(-dot_reg) >> FRAC_BITS;
        inv_sum = {1'b0, inv_reg[0]} + {1'b0, inv_reg[1]};
        emin = (rest_reg[0] < rest_reg[1]) ? 32'(rest_reg[0]) : 32'(rest_reg[1]);
        rv = 33'(vel_reg[3 + 32'(idx_reg)]) - 33'(vel_reg[idx_reg]);
        dprod = 64'(rv) * 64'(nh_reg[idx_reg]);
        nhmag = nh_reg[idx_reg][33] ? 32'(-nh_reg[idx_reg]) : 32'(nh_reg[idx_reg]);
        // The scaled impulse stays below 2^35 and a normal component at or below one.
        prod = 64'(s_reg[34:0]) * 64'(nhmag[FRAC_BITS:0]);
        vi = body_reg ? 3'(3 + 32'(idx_reg)) : 3'(idx_reg);
        vnew = body_reg ? (36'(vel_reg[vi]) + (nh_reg[idx_reg][33]
                              ? -36'(prod >> FRAC_BITS) : 36'(prod >> FRAC_BITS)))
                        : (36'(vel_reg[vi]) - (nh_reg[idx_reg][33]
                              ? -36'(prod >> FRAC_BITS) : 36'(prod >> FRAC_BITS)));
        if (vnew > 36'sh7FFFFFFF)       vsat = 32'sh7FFFFFFF;
        else if (vnew < -36'sh80000000) vsat = 32'sh80000000;
        else                            vsat = vnew[31:0];
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data.which_body      = out_body_reg;
    assign m_data.new_vel_x       = vel_reg[out_body_reg ? 3 : 0];
    assign m_data.new_vel_y       = vel_reg[out_body_reg ? 4 : 1];
    assign m_data.new_vel_z       = vel_reg[out_body_reg ? 5 : 2];
    assign m_data.impulse_applied = applied_reg;
    assign m_data.last_result     = out_body_reg;

    always_comb begin
        state_next = state_reg;
        req = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_data.mode == cir_pkg::ModeContact) begin
                    state_next = ST_INV0;
                end
            end
            ST_INV0, ST_INV1: begin
                if (!wait_reg) begin
                    req.start = 1'b1;
                    req.num = OneSq;
                    req.den = {32'd0, mass_reg[(state_reg == ST_INV1) ? 1 : 0]};
                end else if (rsp.done) begin
                    state_next = (state_reg == ST_INV0) ? ST_INV1 : ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (!wait_reg) begin
                    req.start = (idx_reg == 2'd3);
                    req.is_sqrt = 1'b1;
                    req.num = len_reg;
                end else if (rsp.done) begin
                    state_next = (inv_sum == 33'd0 || rsp.quo == 64'd0) ? ST_OUT : ST_NORM;
                end
            end
            ST_NORM: begin
                if (!wait_reg) begin
                    req.start = 1'b1;
                    req.num = 64'(nmag) << FRAC_BITS;
                    req.den = len_reg;
                end else if (rsp.done && idx_reg == 2'd2) begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                if (idx_reg == 2'd2) state_next = ST_NUM;
            end
            ST_NUM: begin
                state_next = (dot_reg > 96'sd0) ? ST_OUT : ST_SHARE;
            end
            ST_SHARE: begin
                if (!wait_reg) begin
                    req.start = 1'b1;
                    req.num = {32'd0, inv_reg[body_reg]} << FRAC_BITS;
                    req.den = {31'd0, inv_sum};
                end else if (rsp.done) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                state_next = ST_CNT;
            end
            ST_CNT: begin
                if (cnt_reg == 5'd0) begin
                    state_next = ST_APPLY;
                end else if (!wait_reg) begin
                    req.start = 1'b1;
                    req.num = s_reg;
                    req.den = {59'd0, cnt_reg};
                end else if (rsp.done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (idx_reg == 2'd2) state_next = body_reg ? ST_OUT : ST_SHARE;
            end
            ST_OUT: begin
                if (m_ready && out_body_reg) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wait_reg <= 1'b0;
            idx_reg <= '0;
            body_reg <= 1'b0;
            out_body_reg <= 1'b0;
            applied_reg <= 1'b0;
            for (int i = 0; i < 6; i++) vel_reg[i] <= '0;
            mass_reg[0] <= '0;
            mass_reg[1] <= '0;
            rest_reg[0] <= '0;
            rest_reg[1] <= '0;
        end else begin
            state_reg <= state_next;
            if (req.start) wait_reg <= 1'b1;
            if (rsp.done) wait_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_data.mode == cir_pkg::ModeLoad0 ||
                            s_data.mode == cir_pkg::ModeLoad1) begin
                            vel_reg[s_data.mode[0] ? 3 : 0] <= s_data.vec_x;
                            vel_reg[s_data.mode[0] ? 4 : 1] <= s_data.vec_y;
                            vel_reg[s_data.mode[0] ? 5 : 2] <= s_data.vec_z;
                            mass_reg[s_data.mode[0]] <= s_data.mass_value;
                            rest_reg[s_data.mode[0]] <= s_data.restitution;
                        end
                        n_reg[0] <= s_data.vec_x;
                        n_reg[1] <= s_data.vec_y;
                        n_reg[2] <= s_data.vec_z;
                        cnt_reg <= (32'(s_data.contact_count) > MaxCnt)
                                   ? 5'(MaxCnt) : s_data.contact_count;
                        idx_reg <= '0;
                        body_reg <= 1'b0;
                        out_body_reg <= 1'b0;
                        applied_reg <= 1'b0;
                        len_reg <= '0;
                        dot_reg <= '0;
                    end
                end
                ST_INV0, ST_INV1: begin
                    if (wait_reg && rsp.done) begin
                        inv_reg[(state_reg == ST_INV1) ? 1 : 0] <=
                            (mass_reg[(state_reg == ST_INV1) ? 1 : 0] == 32'd0) ? 32'd0 :
                            (rsp.quo > 64'hFFFFFFFF) ? 32'hFFFFFFFF : rsp.quo[31:0];
                    end
                end
                ST_SQRT: begin
                    // Sum of squares one component per cycle, then the root.
                    if (!wait_reg && idx_reg != 2'd3) begin
                        len_reg <= len_reg + sumsq;
                        idx_reg <= idx_reg + 2'd1;
                    end else if (wait_reg && rsp.done) begin
                        len_reg <= rsp.quo;
                        idx_reg <= '0;
                    end
                end
                ST_NORM: begin
                    if (wait_reg && rsp.done) begin
                        nh_reg[idx_reg] <= n_reg[idx_reg][31] ? -34'(rsp.quo[32:0])
                                                              : 34'(rsp.quo[32:0]);
                        idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    end
                end
                ST_DOT: begin
                    dot_reg <= dot_reg + 96'(dprod);
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
                ST_NUM: begin
                    num_reg <= (64'(closing[33:0]) * 64'(18'd65536 + 18'(emin))) >> 16;
                    applied_reg <= (dot_reg <= 96'sd0);
                end
                ST_SHARE: begin
                    if (wait_reg && rsp.done) s_reg <= rsp.quo;
                end
                ST_SCALE: begin
                    s_reg <= (64'(num_reg[34:0]) * 64'(s_reg[FRAC_BITS:0])) >> FRAC_BITS;
                end
                ST_CNT: begin
                    if (wait_reg && rsp.done) s_reg <= rsp.quo;
                end
                ST_APPLY: begin
                    vel_reg[vi] <= vsat;
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    if (idx_reg == 2'd2) body_reg <= 1'b1;
                end
                ST_OUT: begin
                    if (m_ready) out_body_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: hw/rtl/cir_divider.sv
// Shared radix-2 restoring divider and integer square root, one bit per cycle.
module cir_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  cir_pkg::div_req_t req,
    output cir_pkg::div_rsp_t rsp
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        sqrt_reg, sqrt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [65:0] trial;
    logic [65:0] rem_sh;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        sqrt_next = sqrt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = '0;
        trial     = '0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = '0;
            num_next  = req.num;
            den_next  = req.den;
            sqrt_next = req.is_sqrt;
            cnt_next  = req.is_sqrt ? 7'd32 : 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sqrt_reg) begin
                // Two radicand bits per step; trial subtrahend is 4q+1.
                rem_sh   = {rem_reg, num_reg[63:62]};
                trial    = rem_sh - {quo_reg, 2'b01};
                num_next = {num_reg[61:0], 2'b00};
                if (!trial[65]) begin
                    rem_next = trial[63:0];
                    quo_next = {quo_reg[62:0], 1'b1};
                end else begin
                    rem_next = rem_sh[63:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
            end else begin
                rem_sh   = {1'b0, rem_reg, num_reg[63]};
                trial    = rem_sh - {2'b00, den_reg};
                num_next = {num_reg[62:0], 1'b0};
                if (!trial[65]) begin
                    rem_next = trial[63:0];
                    quo_next = {quo_reg[62:0], 1'b1};
                end else begin
                    rem_next = rem_sh[63:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        sqrt_reg <= sqrt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the contact impulse resolver, with a driver, monitor and checker.
`timescale 1ns / 100ps

module testbench;

    // The block has no parameter overrides here, so the predictor uses the defaults.
    localparam int MaxContacts = cir_pkg::MaxContactsDef;
    localparam int Frac        = cir_pkg::FracBitsDef;
    localparam logic [1:0] ModeUnused = 2'd3;

    // This wait covers a whole contact item after the last expected beat.
    localparam int DrainCycles = 800;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cir_pkg::in_beat_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    cir_pkg::out_beat_t m_data;

    contact_impulse_resolver DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Input beats waiting to be sent, and output beats that the predictor has
    // worked out but that the block has not delivered yet.
    cir_pkg::in_beat_t  pending_beats[$];
    cir_pkg::out_beat_t expected_velocities[$];
    int                 error_count = 0;

    // The predictor's own copy of the two bodies, cleared like the block's.
    logic signed [31:0]       body_vel[6] = '{default: '0};
    logic [31:0]              body_mass[2] = '{default: '0};
    logic [cir_pkg::ResW-1:0] body_rest[2] = '{default: '0};

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("testbench: errors");
        $finish;
    end

    // Integer square root, rounded down, done one result bit at a time.
    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned res;
        longint unsigned bit_val;
        res = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > x) bit_val = bit_val >> 2;
        while (bit_val != 0) begin
            if (x >= res + bit_val) begin
                x = x - (res + bit_val);
                res = (res >> 1) + bit_val;
            end else begin
                res = res >> 1;
            end
            bit_val = bit_val >> 2;
        end
        return res;
    endfunction

    // Inverse mass in Q16.16. Mass zero is immovable and gives zero.
    function automatic longint unsigned inverse_mass(input logic [31:0] mass);
        longint unsigned q;
        if (mass == 0) return 0;
        q = (64'd1 << (2 * Frac)) / {32'd0, mass};
        return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Applies one accepted beat to the body copies. A contact beat also
    // queues the two velocity beats that the block must send back.
    task automatic resolve_beat(input cir_pkg::in_beat_t beat);
        longint unsigned inv[2];
        longint unsigned inv_sum, sumsq, len, closing, num, e_min, count, share, s, step;
        longint          n[3];
        longint          nh[3];
        longint          dot, v;
        logic            applied;
        cir_pkg::out_beat_t res;
        if (beat.mode == cir_pkg::ModeLoad0 || beat.mode == cir_pkg::ModeLoad1) begin
            body_vel[beat.mode * 3 + 0] = beat.vec_x;
            body_vel[beat.mode * 3 + 1] = beat.vec_y;
            body_vel[beat.mode * 3 + 2] = beat.vec_z;
            body_mass[beat.mode] = beat.mass_value;
            body_rest[beat.mode] = beat.restitution;
            return;
        end
        if (beat.mode != cir_pkg::ModeContact) return;

        inv[0] = inverse_mass(body_mass[0]);
        inv[1] = inverse_mass(body_mass[1]);
        inv_sum = inv[0] + inv[1];
        n[0] = beat.vec_x;
        n[1] = beat.vec_y;
        n[2] = beat.vec_z;
        sumsq = 0;
        for (int i = 0; i < 3; i++) sumsq = sumsq + magnitude(n[i]) * magnitude(n[i]);
        len = root_floor(sumsq);
        applied = 1'b0;
        dot = 0;

        if (inv_sum != 0 && len != 0) begin
            for (int i = 0; i < 3; i++) begin
                nh[i] = longint'((magnitude(n[i]) << Frac) / len);
                if (n[i] < 0) nh[i] = -nh[i];
                dot = dot + (longint'(body_vel[3 + i]) - longint'(body_vel[i])) * nh[i];
            end
            // Separating bodies get no impulse. A zero closing speed still
            // counts as applied, even though nothing moves.
            if (dot <= 0) begin
                applied = 1'b1;
                closing = magnitude(dot) >> Frac;
                e_min = (body_rest[0] < body_rest[1]) ? body_rest[0] : body_rest[1];
                num = (closing * (64'd65536 + e_min)) >> 16;
                count = {59'd0, beat.contact_count};
                if (count > MaxContacts) count = MaxContacts;
                for (int b = 0; b < 2; b++) begin
                    share = (inv[b] << Frac) / inv_sum;
                    s = (num * share) >> Frac;
                    if (count != 0) s = s / count;
                    for (int i = 0; i < 3; i++) begin
                        step = (s * magnitude(nh[i])) >> Frac;
                        v = body_vel[b * 3 + i];
                        if ((nh[i] < 0) == (b == 0)) v = v + longint'(step);
                        else v = v - longint'(step);
                        if (v > 64'sd2147483647) v = 64'sd2147483647;
                        if (v < -64'sd2147483648) v = -64'sd2147483648;
                        body_vel[b * 3 + i] = v[31:0];
                    end
                end
            end
        end

        for (int b = 0; b < 2; b++) begin
            res.which_body = b[0];
            res.new_vel_x = body_vel[b * 3 + 0];
            res.new_vel_y = body_vel[b * 3 + 1];
            res.new_vel_z = body_vel[b * 3 + 2];
            res.impulse_applied = applied;
            res.last_result = b[0];
            expected_velocities.push_back(res);
        end
    endtask

    function automatic cir_pkg::in_beat_t body_beat(input logic [1:0] mode,
                                                    input logic [31:0] vx,
                                                    input logic [31:0] vy,
                                                    input logic [31:0] vz,
                                                    input logic [31:0] mass,
                                                    input logic [cir_pkg::ResW-1:0] rest);
        cir_pkg::in_beat_t beat;
        beat = '0;
        beat.mode = mode;
        beat.vec_x = vx;
        beat.vec_y = vy;
        beat.vec_z = vz;
        beat.mass_value = mass;
        beat.restitution = rest;
        return beat;
    endfunction

    function automatic cir_pkg::in_beat_t contact_beat(input logic [31:0] nx,
                                                       input logic [31:0] ny,
                                                       input logic [31:0] nz,
                                                       input logic [cir_pkg::CntW-1:0] count);
        cir_pkg::in_beat_t beat;
        beat = '0;
        beat.mode = cir_pkg::ModeContact;
        beat.vec_x = nx;
        beat.vec_y = ny;
        beat.vec_z = nz;
        beat.contact_count = count;
        return beat;
    endfunction

    // Velocities are mostly moderate so that impulses stay in range. Now and
    // then a fully random word exercises every bit and saturation.
    function automatic logic [31:0] rand_velocity();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h8000_0000 | $urandom_range(0, 255);
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $urandom();
            2: return $urandom_range(1, 255);
            default: return $urandom_range(32'h0000_4000, 32'h0040_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_normal();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'd0;
            default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic [cir_pkg::ResW-1:0] rand_rest();
        logic [31:0] r;
        r = $urandom_range(0, 65536);
        return r[cir_pkg::ResW-1:0];
    endfunction

    // Stimulus: a directed opening, then mostly well-formed load, load,
    // contact sequences with some noise beats mixed in.
    initial begin
        logic [1:0]  noise_mode;
        logic [31:0] noise_word;
        logic [31:0] count_word;
        // Both bodies immovable after reset.
        pending_beats.push_back(contact_beat(32'h0001_0000, 0, 0, 5'd1));
        // Zero normal with movable bodies.
        pending_beats.push_back(body_beat(cir_pkg::ModeLoad0, 32'h0001_0000, 0, 0,
                                          32'h0001_0000, 17'd0));
        pending_beats.push_back(body_beat(cir_pkg::ModeLoad1, 32'hFFFF_0000, 0, 0,
                                          32'h0001_0000, 17'd65536));
        pending_beats.push_back(contact_beat(0, 0, 0, 5'd1));
        // Approaching along +x, restitution one and zero, count zero.
        pending_beats.push_back(contact_beat(32'h0001_0000, 0, 0, 5'd0));
        // The same contact again after the bounce, which left both bodies at rest.
        pending_beats.push_back(contact_beat(32'h0001_0000, 0, 0, 5'd0));
        // Zero closing speed: same velocity for both bodies.
        pending_beats.push_back(body_beat(cir_pkg::ModeLoad0, 32'h0002_0000, 32'h0001_0000, 0,
                                          32'h0002_0000, 17'h1FFFF));
        pending_beats.push_back(body_beat(cir_pkg::ModeLoad1, 32'h0002_0000, 32'h0001_0000, 0,
                                          32'd1, 17'h1FFFF));
        pending_beats.push_back(contact_beat(32'h0000_3000, 32'hFFFF_9000, 32'd7, 5'd31));
        // Extreme velocities and masses; count above the maximum.
        pending_beats.push_back(body_beat(cir_pkg::ModeLoad0, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'd65535));
        pending_beats.push_back(body_beat(cir_pkg::ModeLoad1, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h8000_0000, 32'd1, 17'd1));
        pending_beats.push_back(contact_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 5'd17));
        pending_beats.push_back(contact_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 5'd16));
        // Unused mode is dropped and must not disturb the bodies.
        pending_beats.push_back(body_beat(ModeUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 17'h1FFFF));
        pending_beats.push_back(contact_beat(32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000, 5'd3));
        // One body immovable, the other light.
        pending_beats.push_back(body_beat(cir_pkg::ModeLoad0, 32'h0000_8000, 32'hFFFF_0000,
                                          32'h0003_0000, 32'd0, 17'd40000));
        pending_beats.push_back(body_beat(cir_pkg::ModeLoad1, 32'hFFFD_0000, 32'h0001_0000,
                                          32'h0000_0000, 32'h0000_8000, 17'd20000));
        pending_beats.push_back(contact_beat(32'h0000_5A82, 32'hFFFF_A57E, 32'd0, 5'd2));

        while (pending_beats.size() < 1650) begin
            if ($urandom_range(0, 9) == 0) begin
                noise_word = $urandom_range(0, 3);
                noise_mode = noise_word[1:0];
                noise_word = $urandom();
                count_word = $urandom();
                pending_beats.push_back(body_beat(noise_mode, $urandom(), $urandom(), $urandom(),
                                                  $urandom(),
                                                  noise_word[cir_pkg::ResW-1:0]));
                pending_beats[$].contact_count = count_word[cir_pkg::CntW-1:0];
            end else begin
                if ($urandom_range(0, 3) != 0)
                    pending_beats.push_back(body_beat(cir_pkg::ModeLoad0, rand_velocity(),
                                                      rand_velocity(), rand_velocity(),
                                                      rand_mass(), rand_rest()));
                if ($urandom_range(0, 3) != 0)
                    pending_beats.push_back(body_beat(cir_pkg::ModeLoad1, rand_velocity(),
                                                      rand_velocity(), rand_velocity(),
                                                      rand_mass(), rand_rest()));
                count_word = $urandom_range(0, 31);
                pending_beats.push_back(contact_beat(rand_normal(), rand_normal(), rand_normal(),
                                                     count_word[cir_pkg::CntW-1:0]));
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for everything to go out and come back, then for the block to
        // settle so that a stray extra beat would still be caught.
        wait (pending_beats.size() == 0 && !s_valid && expected_velocities.size() == 0);
        repeat (DrainCycles) @(posedge aclk);
        if (error_count == 0 && expected_velocities.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // In the last stretch of the run neither side starts new idle bursts.
    function automatic bit quiet_phase();
        return pending_beats.size() < 150;
    endfunction

    // Driver: feeds the block from the queue, with random idle bursts
    // between beats. Valid is only ever lowered after an accept.
    int sender_idle = 0;
    always @(posedge aclk) begin
        logic              next_valid;
        cir_pkg::in_beat_t next_data;
        next_valid = s_valid;
        next_data = s_data;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                resolve_beat(s_data);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (sender_idle > 0) begin
                    sender_idle--;
                end else if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
                    sender_idle = $urandom_range(0, 3);
                end else if (pending_beats.size() > 0) begin
                    next_data = pending_beats.pop_front();
                    next_valid = 1'b1;
                end
            end
        end
        s_valid <= next_valid;
        s_data <= next_data;
    end

    // Monitor: checks every delivered beat against the oldest expectation.
    // Early on the receiver holds off once for a long stretch so that the
    // block sits full while the driver keeps offering a beat.
    int receiver_idle = 0;
    int beats_seen = 0;
    bit long_hold_done = 0;
    always @(posedge aclk) begin
        cir_pkg::out_beat_t want;
        logic               next_ready;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (expected_velocities.size() == 0) begin
                error_count++;
                $display("%0t: unexpected beat, expected none, actual %p", $realtime, m_data);
            end else begin
                want = expected_velocities.pop_front();
                if (m_data.which_body !== want.which_body) begin
                    error_count++;
                    $display("%0t: which_body expected %0d actual %0d", $realtime,
                             want.which_body, m_data.which_body);
                end
                if (m_data.new_vel_x !== want.new_vel_x) begin
                    error_count++;
                    $display("%0t: new_vel_x expected %h actual %h", $realtime,
                             want.new_vel_x, m_data.new_vel_x);
                end
                if (m_data.new_vel_y !== want.new_vel_y) begin
                    error_count++;
                    $display("%0t: new_vel_y expected %h actual %h", $realtime,
                             want.new_vel_y, m_data.new_vel_y);
                end
                if (m_data.new_vel_z !== want.new_vel_z) begin
                    error_count++;
                    $display("%0t: new_vel_z expected %h actual %h", $realtime,
                             want.new_vel_z, m_data.new_vel_z);
                end
                if (m_data.impulse_applied !== want.impulse_applied) begin
                    error_count++;
                    $display("%0t: impulse_applied expected %0d actual %0d", $realtime,
                             want.impulse_applied, m_data.impulse_applied);
                end
                if (m_data.last_result !== want.last_result) begin
                    error_count++;
                    $display("%0t: last_result expected %0d actual %0d", $realtime,
                             want.last_result, m_data.last_result);
                end
            end
        end

        if (!long_hold_done && beats_seen == 40) begin
            long_hold_done = 1;
            receiver_idle = 3000;
        end
        if (receiver_idle > 0) begin
            receiver_idle--;
            next_ready = 1'b0;
        end else if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
            receiver_idle = $urandom_range(0, 3);
            next_ready = 1'b0;
        end else begin
            next_ready = 1'b1;
        end
        m_ready <= next_ready;
    end

endmodule

FILE: files.f
hw/rtl/cir_pkg.sv
hw/rtl/cir_divider.sv
hw/rtl/contact_impulse_resolver.sv
sim/testbench.sv
